// File: hw/rtl/ssq_pkg.sv
// Shared types, widths and codes of the stable sorted priority queue.
package ssq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int KEY_BITS    = 27;
	localparam int TAG_BITS    = 16;
	localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

	// input tdata layout: entry_key, entry_tag
	localparam int S_KEY_LSB   = 0;
	localparam int S_TAG_LSB   = S_KEY_LSB + KEY_BITS;
	localparam int S_USED_BITS = S_TAG_LSB + TAG_BITS;
	localparam int S_DATA_BITS = ((S_USED_BITS + 7) / 8) * 8;

	// output tdata layout: popped_key, popped_tag, head_valid, head_key, head_tag, entry_count
	localparam int M_PKEY_LSB  = 0;
	localparam int M_PTAG_LSB  = M_PKEY_LSB + KEY_BITS;
	localparam int M_HVAL_LSB  = M_PTAG_LSB + TAG_BITS;
	localparam int M_HKEY_LSB  = M_HVAL_LSB + 1;
	localparam int M_HTAG_LSB  = M_HKEY_LSB + KEY_BITS;
	localparam int M_CNT_LSB   = M_HTAG_LSB + TAG_BITS;
	localparam int M_USED_BITS = M_CNT_LSB + COUNT_BITS;
	localparam int M_DATA_BITS = ((M_USED_BITS + 7) / 8) * 8;

	localparam int STATUS_BITS = 2;
	localparam int M_USER_BITS = 8;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [TAG_BITS-1:0]   tag_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic latch;    // capture the accepted input transaction
		logic compare;  // register the slot compare vector
		logic apply;    // update the slots and the result register
	} ssq_ctl_t;

endpackage

// File: hw/rtl/ssq_ctrl.sv
// Sequencer of the queue: accept, compare, apply, and the output valid flag.
module ssq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output ssq_pkg::ssq_ctl_t ctl
);
	import ssq_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		COMPARE,
		APPLY
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   apply_go;

	// apply only when the result register is free or being drained
	assign apply_go    = (state_q == APPLY) && (!out_valid_q || m_tready);
	assign s_tready    = (state_q == IDLE);
	assign m_tvalid    = out_valid_q;
	assign ctl.latch   = s_tvalid && (state_q == IDLE);
	assign ctl.compare = (state_q == COMPARE);
	assign ctl.apply   = apply_go;

	// hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) state_q <= COMPARE;
				end
				COMPARE: begin
					state_q <= APPLY;
				end
				APPLY: begin
					if (apply_go) state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
			if (apply_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/ssq_datapath.sv
// Sorted slot array with parallel compare, insert and shift, and the result register.
module ssq_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ssq_pkg::ssq_ctl_t                ctl,
	input  logic                             cfg_wr_en,
	input  logic                             cfg_wr_data,
	input  logic [ssq_pkg::S_DATA_BITS-1:0]  s_tdata,
	input  logic                             s_tuser,
	output logic [ssq_pkg::M_DATA_BITS-1:0]  m_tdata,
	output logic [ssq_pkg::M_USER_BITS-1:0]  m_tuser
);
	import ssq_pkg::*;

	cmd_t    cmd_q;
	key_t    key_q;
	tag_t    tag_q;
	logic    asc_q;
	count_t  count_q;
	key_t    slot_key_q [QUEUE_DEPTH];
	tag_t    slot_tag_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] stop_s1;

	status_t status_q;
	key_t    popped_key_q;
	tag_t    popped_tag_q;

	logic [QUEUE_DEPTH-1:0] at_or_after;
	logic [QUEUE_DEPTH-1:0] first_at;
	key_t    prev_key [QUEUE_DEPTH];
	tag_t    prev_tag [QUEUE_DEPTH];
	key_t    next_key [QUEUE_DEPTH];
	tag_t    next_tag [QUEUE_DEPTH];
	logic    is_full;
	logic    is_empty;
	logic    push_ok;
	logic    pop_ok;
	logic    head_valid;
	key_t    head_key;
	tag_t    head_tag;

	// true when a new key must go behind a held key
	function automatic logic goes_behind(input logic asc, input key_t held, input key_t fresh);
		if (asc) return held <= fresh;
		return held >= fresh;
	endfunction

	// capture the accepted transaction
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd_t'(s_tuser);
			key_q <= s_tdata[S_KEY_LSB +: KEY_BITS];
			tag_q <= s_tdata[S_TAG_LSB +: TAG_BITS];
		end
	end

	// compare the fresh key against every slot; unused slots always stop the scan
	always_ff @(posedge clk) begin
		if (ctl.compare) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				stop_s1[i] <= !((count_q > COUNT_BITS'(i)) &&
					goes_behind(asc_q, slot_key_q[i], key_q));
			end
		end
	end

	// find the insert slot and the shifted neighbors
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			at_or_after[i] = |(stop_s1 & ({QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - i)));
		end
		first_at = at_or_after & ~{at_or_after[QUEUE_DEPTH-2:0], 1'b0};
		prev_key[0] = key_q;
		prev_tag[0] = tag_q;
		for (int i = 1; i < QUEUE_DEPTH; i++) begin
			prev_key[i] = slot_key_q[i-1];
			prev_tag[i] = slot_tag_q[i-1];
		end
		next_key[QUEUE_DEPTH-1] = slot_key_q[QUEUE_DEPTH-1];
		next_tag[QUEUE_DEPTH-1] = slot_tag_q[QUEUE_DEPTH-1];
		for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
			next_key[i] = slot_key_q[i+1];
			next_tag[i] = slot_tag_q[i+1];
		end
	end

	assign is_full  = (count_q == COUNT_BITS'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign push_ok  = (cmd_q == CMD_PUSH) && !is_full;
	assign pop_ok   = (cmd_q == CMD_POP) && !is_empty;

	// insert after ties, or advance every slot toward the head on pop
	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (push_ok && first_at[i]) begin
					slot_key_q[i] <= key_q;
					slot_tag_q[i] <= tag_q;
				end else if (push_ok && at_or_after[i]) begin
					slot_key_q[i] <= prev_key[i];
					slot_tag_q[i] <= prev_tag[i];
				end else if (pop_ok) begin
					slot_key_q[i] <= next_key[i];
					slot_tag_q[i] <= next_tag[i];
				end
			end
		end
	end

	// result register: status and the removed entry
	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			if (cmd_q == CMD_PUSH) begin
				status_q <= is_full ? ST_FULL : ST_OK;
			end else begin
				status_q <= is_empty ? ST_EMPTY : ST_OK;
			end
			popped_key_q <= pop_ok ? slot_key_q[0] : '0;
			popped_tag_q <= pop_ok ? slot_tag_q[0] : '0;
		end
	end

	// fill count and order bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			asc_q   <= 1'b0;
		end else begin
			if (ctl.apply && push_ok) begin
				count_q <= count_q + COUNT_BITS'(1);
			end else if (ctl.apply && pop_ok) begin
				count_q <= count_q - COUNT_BITS'(1);
			end
			if (cfg_wr_en) asc_q <= cfg_wr_data;
		end
	end

	// the slots only change while the result register is free or being drained, so the head reads live
	assign head_valid = !is_empty;
	assign head_key   = head_valid ? slot_key_q[0] : '0;
	assign head_tag   = head_valid ? slot_tag_q[0] : '0;

	always_comb begin
		m_tdata = '0;
		m_tdata[M_PKEY_LSB +: KEY_BITS]   = popped_key_q;
		m_tdata[M_PTAG_LSB +: TAG_BITS]   = popped_tag_q;
		m_tdata[M_HVAL_LSB]               = head_valid;
		m_tdata[M_HKEY_LSB +: KEY_BITS]   = head_key;
		m_tdata[M_HTAG_LSB +: TAG_BITS]   = head_tag;
		m_tdata[M_CNT_LSB +: COUNT_BITS]  = count_q;
		m_tuser = '0;
		m_tuser[STATUS_BITS-1:0] = status_q;
	end

endmodule

// File: hw/rtl/stable_sorted_priority_queue_unit.sv
// Top level of the stable sorted priority queue: sequencer plus slot datapath.
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tdata: entry_key, entry_tag; tuser: cmd
//  m_*      out        m_tvalid/m_tready  tdata: popped_key .. entry_count; tuser: status
//  cfg_*    in         cfg_wr_en          cfg_wr_data: ascending_order
//
// An item passes through three steps: accept, a registered compare of all slots against
// the key, then the insert or shift; the result is valid the cycle after that.
// The next item is accepted while a result waits; its update step stalls until
// the output register is taken. Reset clears the count and the order bit; slot
// contents are not cleared and no clearing pass is needed.
module stable_sorted_priority_queue_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic                             cfg_wr_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ssq_pkg::S_DATA_BITS-1:0]  s_tdata,  // entry_key, entry_tag, zero pad
	input  logic                             s_tuser,  // cmd
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ssq_pkg::M_DATA_BITS-1:0]  m_tdata,  // popped_key, popped_tag, head_valid,
	                                                   // head_key, head_tag, entry_count, pad
	output logic [ssq_pkg::M_USER_BITS-1:0]  m_tuser   // status, zero pad
);
	import ssq_pkg::*;

	ssq_ctl_t ctl;

	ssq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl)
	);

	ssq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule

// File: hw/rtl/ssq_checker.sv
// Port-level checks of the queue, bound to the top level.
module ssq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [ssq_pkg::M_DATA_BITS-1:0]  m_tdata,
	input logic [ssq_pkg::M_USER_BITS-1:0]  m_tuser
);
	import ssq_pkg::*;

	logic [COUNT_BITS-1:0]  cnt;
	logic [STATUS_BITS-1:0] st;

	assign cnt = m_tdata[M_CNT_LSB +: COUNT_BITS];
	assign st  = m_tuser[STATUS_BITS-1:0];

	// a stalled result transaction stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// count never exceeds the depth and agrees with the head flag
	a_count_head: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cnt <= COUNT_BITS'(QUEUE_DEPTH)) && (m_tdata[M_HVAL_LSB] == (cnt != '0)))
		else $error("count and head flag disagree");

	// a failed operation removes nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st != ST_OK) |->
			(m_tdata[M_PKEY_LSB +: KEY_BITS] == '0) && (m_tdata[M_PTAG_LSB +: TAG_BITS] == '0))
		else $error("failed operation reports a removed entry");

	// a full flag only appears with a full queue, an empty flag only with an empty one
	a_flag_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((st != ST_FULL) || (cnt == COUNT_BITS'(QUEUE_DEPTH))) &&
			((st != ST_EMPTY) || (cnt == '0)))
		else $error("status flag does not match count");

endmodule

bind stable_sorted_priority_queue_unit ssq_checker u_ssq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
